// File: rtl/g2c_pkg.sv
// ---------------------------------------------------------------------------
// g2c_pkg
// Shared constants, types and helper functions for the geodetic to
// Cartesian converter.
// ---------------------------------------------------------------------------
package g2c_pkg;

	localparam int CORDIC_STAGES = 32;
	localparam int STG_W = $clog2(CORDIC_STAGES);
	localparam int SQ_BITS = 58;
	localparam int SQB_W = 6;
	localparam int GW = 116;
	localparam int NUMW = 118;
	localparam int HTW = 56;
	localparam int DIV_STEPS = 64;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam logic [63:0] INV_SQRT2_Q64 = 64'hB504F333F9DE6484;
	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
	localparam logic [63:0] QUOT_CAP = 64'h4000000000000000;
	localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
	localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;
	localparam logic [39:0] POS_MAX = 40'h7FFFFFFFFF;
	localparam logic [39:0] POS_MIN = 40'h8000000000;
	localparam logic signed [63:0] ROUND_HALF = 64'sd524288;

	localparam logic [49:0] RSQ_EQ_RST = 50'd40680631590769;
	localparam logic [49:0] RSQ_POLAR_RST = 50'd40408299984659;

	localparam logic [1:0] CFG_RSQ_X = 2'd0;
	localparam logic [1:0] CFG_RSQ_Y = 2'd1;
	localparam logic [1:0] CFG_RSQ_Z = 2'd2;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} cordic_lane_t;

	typedef struct packed {
		logic [1:0] quad_lat;
		logic [1:0] quad_lon;
		logic [31:0] height;
	} cside_t;

	typedef struct packed {
		logic lat_neg;
		logic lon_neg;
		cside_t side;
	} front_t;

	typedef struct packed {
		logic [1:0] quad;
		logic neg;
		logic [29:0] mag;
	} ang_split_t;

	typedef struct packed {
		logic signed [63:0] c;
		logic signed [63:0] s;
	} cs_t;

	typedef struct packed {
		logic [2:0] neg;
		logic [2:0][NUMW-1:0] num;
		logic [2:0][HTW-1:0] ht;
	} post_t;

	typedef struct packed {
		logic [57:0] rem;
		logic [63:0] quo;
		logic zero;
		logic cap;
		logic neg;
		logic [HTW-1:0] ht;
	} div_lane_t;

	typedef struct packed {
		logic [39:0] pos_x;
		logic [39:0] pos_y;
		logic [39:0] pos_z;
	} out_t;

	typedef logic [63:0] atan_tab_t [CORDIC_STAGES];

	function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[63:0], n[k]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] atan_val(input int i);
		logic [63:0] s;
		logic [63:0] t;
		s = '0;
		if (i == 0) return PI_Q60;
		for (int m = 0; m < 32; m++) begin
			if (i * (2 * m + 1) <= 62) begin
				t = cdiv(ONE_Q62 >> (i * (2 * m + 1)), 64'(2 * m + 1));
				if (m[0]) s = s - t;
				else s = s + t;
			end
		end
		return s;
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t tb;
		for (int i = 0; i < CORDIC_STAGES; i++) tb[i] = atan_val(i);
		return tb;
	endfunction

	function automatic logic [63:0] inv_gain();
		logic [63:0] k;
		logic [63:0] f;
		logic [63:0] t;
		logic [127:0] p;
		logic done;
		k = INV_SQRT2_Q64 >> 2;
		for (int i = 1; i < CORDIC_STAGES; i++) begin
			f = ONE_Q62;
			t = ONE_Q62;
			done = 1'b0;
			if (2 * i < 63) begin
				for (int m = 1; m < 64; m++) begin
					if (!done) begin
						t = t >> (2 * i);
						t = t - cdiv(t, 64'(2 * m));
						if (t == 64'd0) done = 1'b1;
						else if (m[0]) f = f - t;
						else f = f + t;
					end
				end
			end
			p = 128'(k) * 128'(f);
			k = p[125:62];
		end
		return k >> 2;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();
	localparam logic [63:0] INV_GAIN_Q60 = inv_gain();

	function automatic ang_split_t split_angle(input logic [31:0] a);
		logic [31:0] sh;
		logic signed [30:0] r;
		ang_split_t o;
		sh = a + 32'h20000000;
		r = $signed({1'b0, sh[29:0]}) - 31'sd536870912;
		o.quad = sh[31:30];
		o.neg = r[30];
		o.mag = r[30] ? 30'(-r) : 30'(r);
		return o;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] with_sign(input logic [62:0] m, input logic neg);
		logic signed [63:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

	function automatic cs_t quad_map(input logic [1:0] q, input cordic_lane_t l);
		cs_t o;
		case (q)
			2'd0: begin
				o.c = l.x;
				o.s = l.y;
			end
			2'd1: begin
				o.c = -l.y;
				o.s = l.x;
			end
			2'd2: begin
				o.c = -l.x;
				o.s = -l.y;
			end
			default: begin
				o.c = l.y;
				o.s = -l.x;
			end
		endcase
		return o;
	endfunction

endpackage

// File: rtl/g2c_if.sv
// ---------------------------------------------------------------------------
// g2c_if
// Valid/ready channel interfaces for coordinate input and position output.
// ---------------------------------------------------------------------------
interface g2c_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] lat_angle;
	logic signed [31:0] lon_angle;
	logic signed [31:0] height_mm;
	modport source (output valid, output lat_angle, output lon_angle, output height_mm,
		input ready);
	modport sink (input valid, input lat_angle, input lon_angle, input height_mm,
		output ready);
endinterface

interface g2c_out_if;
	logic valid;
	logic ready;
	logic signed [39:0] pos_x;
	logic signed [39:0] pos_y;
	logic signed [39:0] pos_z;
	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// File: rtl/g2c_mul.sv
// ---------------------------------------------------------------------------
// g2c_mul
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 products.
// ---------------------------------------------------------------------------
module g2c_mul (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] p
);
	logic [63:0] pp_s1 [4];
	logic [127:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= a[31:0] * b[31:0];
			pp_s1[1] <= a[31:0] * b[63:32];
			pp_s1[2] <= a[63:32] * b[31:0];
			pp_s1[3] <= a[63:32] * b[63:32];
			p_s2 <= {64'd0, pp_s1[0]} + {32'd0, pp_s1[1], 32'd0}
				+ {32'd0, pp_s1[2], 32'd0} + {pp_s1[3], 64'd0};
		end
	end

	assign p = p_s2;
endmodule

// File: rtl/g2c_cordic_cell.sv
// ---------------------------------------------------------------------------
// g2c_cordic_cell
// One rotation-mode CORDIC stage for the latitude and longitude lanes.
// ---------------------------------------------------------------------------
module g2c_cordic_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [g2c_pkg::STG_W-1:0]  stage,
	input  logic                       in_v,
	input  g2c_pkg::cordic_lane_t      in_lat,
	input  g2c_pkg::cordic_lane_t      in_lon,
	input  g2c_pkg::cside_t            in_side,
	output logic                       out_v,
	output g2c_pkg::cordic_lane_t      out_lat,
	output g2c_pkg::cordic_lane_t      out_lon,
	output g2c_pkg::cside_t            out_side
);
	import g2c_pkg::*;

	logic signed [63:0] at;
	cordic_lane_t lat_nx;
	cordic_lane_t lon_nx;
	logic v_q;
	cordic_lane_t lat_q;
	cordic_lane_t lon_q;
	cside_t side_q;

	function automatic cordic_lane_t rotate(input cordic_lane_t l, input logic [STG_W-1:0] s,
		input logic signed [63:0] a);
		cordic_lane_t o;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		dx = l.y >>> s;
		dy = l.x >>> s;
		if (!l.z[63]) begin
			o.x = l.x - dx;
			o.y = l.y + dy;
			o.z = l.z - a;
		end else begin
			o.x = l.x + dx;
			o.y = l.y - dy;
			o.z = l.z + a;
		end
		return o;
	endfunction

	always_comb begin
		at = $signed(ATAN_TAB[stage]);
		lat_nx = rotate(in_lat, stage, at);
		lon_nx = rotate(in_lon, stage, at);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_q <= lat_nx;
			lon_q <= lon_nx;
			side_q <= in_side;
		end
	end

	assign out_v = v_q;
	assign out_lat = lat_q;
	assign out_lon = lon_q;
	assign out_side = side_q;
endmodule

// File: rtl/g2c_sqrt_cell.sv
// ---------------------------------------------------------------------------
// g2c_sqrt_cell
// One result bit of a restoring integer square root.
// ---------------------------------------------------------------------------
module g2c_sqrt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [g2c_pkg::SQB_W-1:0]    bit_idx,
	input  logic                         in_v,
	input  logic [g2c_pkg::GW-1:0]       in_rem,
	input  logic [g2c_pkg::SQ_BITS-1:0]  in_res,
	input  g2c_pkg::post_t               in_post,
	output logic                         out_v,
	output logic [g2c_pkg::GW-1:0]       out_rem,
	output logic [g2c_pkg::SQ_BITS-1:0]  out_res,
	output g2c_pkg::post_t               out_post
);
	import g2c_pkg::*;

	logic [6:0] sh1;
	logic [6:0] sh2;
	logic [GW-1:0] trial;
	logic take;
	logic v_q;
	logic [GW-1:0] rem_q;
	logic [SQ_BITS-1:0] res_q;
	post_t post_q;

	always_comb begin
		sh1 = 7'(bit_idx) + 7'd1;
		sh2 = {bit_idx, 1'b0};
		trial = (GW'(in_res) << sh1) | (GW'(1) << sh2);
		take = in_rem >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? in_rem - trial : in_rem;
			res_q <= take ? in_res | (SQ_BITS'(1) << bit_idx) : in_res;
			post_q <= in_post;
		end
	end

	assign out_v = v_q;
	assign out_rem = rem_q;
	assign out_res = res_q;
	assign out_post = post_q;
endmodule

// File: rtl/g2c_div_cell.sv
// ---------------------------------------------------------------------------
// g2c_div_cell
// One quotient bit of restoring division for the three axis lanes.
// ---------------------------------------------------------------------------
module g2c_div_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_v,
	input  logic [g2c_pkg::SQ_BITS-1:0]       in_gamma,
	input  g2c_pkg::div_lane_t [2:0]          in_lane,
	output logic                              out_v,
	output logic [g2c_pkg::SQ_BITS-1:0]       out_gamma,
	output g2c_pkg::div_lane_t [2:0]          out_lane
);
	import g2c_pkg::*;

	div_lane_t [2:0] lane_nx;
	logic [58:0] r2;
	logic ge;
	logic v_q;
	logic [SQ_BITS-1:0] gamma_q;
	div_lane_t [2:0] lane_q;

	always_comb begin
		lane_nx = in_lane;
		r2 = '0;
		ge = 1'b0;
		for (int j = 0; j < 3; j++) begin
			r2 = {in_lane[j].rem, in_lane[j].quo[63]};
			ge = r2 >= {1'b0, in_gamma};
			lane_nx[j].rem = ge ? 58'(r2 - {1'b0, in_gamma}) : r2[57:0];
			lane_nx[j].quo = {in_lane[j].quo[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gamma_q <= in_gamma;
			lane_q <= lane_nx;
		end
	end

	assign out_v = v_q;
	assign out_gamma = gamma_q;
	assign out_lane = lane_q;
endmodule

// File: rtl/geodetic_to_cartesian.sv
// ---------------------------------------------------------------------------
// geodetic_to_cartesian
// Converts latitude, longitude and height to an Earth-centered Cartesian
// point on a configurable ellipsoid, one transaction per cycle while not stalled.
// ---------------------------------------------------------------------------
// Channel    Dir  Payload                                 Handshake
// coord_in   in   lat_angle, lon_angle, height_mm (s32)   valid/ready
// coord_out  out  pos_x, pos_y, pos_z (s40, mm)           valid/ready
// cfg        in   cfg_index (2b), cfg_data (50b)          cfg_we
//
// The CORDIC row, a 58-cell square root row and a 64-cell divider row
// dominate the latency. A new transaction is accepted every cycle while
// the output skid register is empty. Reset clears all valid bits;
// there is no clearing pass. The whole pipeline holds only when the output
// skid register is full, so one result may wait while the next is taken.
// ---------------------------------------------------------------------------
module geodetic_to_cartesian (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [49:0]       cfg_data,
	g2c_in_if.sink            coord_in,
	g2c_out_if.source         coord_out
);
	import g2c_pkg::*;

	logic [49:0] r2_q [3];
	logic adv;
	logic in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q[0] <= RSQ_EQ_RST;
			r2_q[1] <= RSQ_EQ_RST;
			r2_q[2] <= RSQ_POLAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RSQ_X: r2_q[0] <= cfg_data;
				CFG_RSQ_Y: r2_q[1] <= cfg_data;
				CFG_RSQ_Z: r2_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: quadrant reduction and residual angle to radians.
	ang_split_t lat_sp;
	ang_split_t lon_sp;
	logic [127:0] plat;
	logic [127:0] plon;
	logic v_s1;
	logic v_s2;
	front_t fr_s1;
	front_t fr_s2;

	assign in_fire = coord_in.valid && coord_in.ready;
	assign lat_sp = split_angle(coord_in.lat_angle);
	assign lon_sp = split_angle(coord_in.lon_angle);

	g2c_mul u_mul_lat (.clk(clk), .en(adv), .a(64'(lat_sp.mag)), .b(TWO_PI_Q60), .p(plat));
	g2c_mul u_mul_lon (.clk(clk), .en(adv), .a(64'(lon_sp.mag)), .b(TWO_PI_Q60), .p(plon));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s1.lat_neg <= lat_sp.neg;
			fr_s1.lon_neg <= lon_sp.neg;
			fr_s1.side.quad_lat <= lat_sp.quad;
			fr_s1.side.quad_lon <= lon_sp.quad;
			fr_s1.side.height <= coord_in.height_mm;
			fr_s2 <= fr_s1;
		end
	end

	// CORDIC row.
	logic cv [CORDIC_STAGES+1];
	cordic_lane_t clat [CORDIC_STAGES+1];
	cordic_lane_t clon [CORDIC_STAGES+1];
	cside_t cside [CORDIC_STAGES+1];

	assign cv[0] = v_s2;
	assign cside[0] = fr_s2.side;
	assign clat[0] = '{x: $signed(INV_GAIN_Q60), y: 64'sd0,
		z: with_sign(plat[92:30], fr_s2.lat_neg)};
	assign clon[0] = '{x: $signed(INV_GAIN_Q60), y: 64'sd0,
		z: with_sign(plon[92:30], fr_s2.lon_neg)};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		g2c_cordic_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .stage(STG_W'(i)),
			.in_v(cv[i]), .in_lat(clat[i]), .in_lon(clon[i]), .in_side(cside[i]),
			.out_v(cv[i+1]), .out_lat(clat[i+1]), .out_lon(clon[i+1]),
			.out_side(cside[i+1])
		);
	end

	// Surface normal.
	cs_t lat_cs;
	cs_t lon_cs;
	logic [127:0] pn0;
	logic [127:0] pn1;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic [1:0] nneg_s3;
	logic [1:0] nneg_s4;
	logic signed [63:0] sl_s3;
	logic signed [63:0] sl_s4;
	logic [31:0] h_s3;
	logic [31:0] h_s4;
	logic signed [63:0] n_s5 [3];
	logic [31:0] h_s5;

	assign lat_cs = quad_map(cside[CORDIC_STAGES].quad_lat, clat[CORDIC_STAGES]);
	assign lon_cs = quad_map(cside[CORDIC_STAGES].quad_lon, clon[CORDIC_STAGES]);

	g2c_mul u_mul_n0 (.clk(clk), .en(adv), .a(mag64(lat_cs.c)), .b(mag64(lon_cs.c)), .p(pn0));
	g2c_mul u_mul_n1 (.clk(clk), .en(adv), .a(mag64(lat_cs.c)), .b(mag64(lon_cs.s)), .p(pn1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= cv[CORDIC_STAGES];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nneg_s3 <= {lat_cs.c[63] ^ lon_cs.s[63], lat_cs.c[63] ^ lon_cs.c[63]};
			sl_s3 <= lat_cs.s;
			h_s3 <= cside[CORDIC_STAGES].height;
			nneg_s4 <= nneg_s3;
			sl_s4 <= sl_s3;
			h_s4 <= h_s3;
			n_s5[0] <= with_sign(pn0[122:60], nneg_s4[0]);
			n_s5[1] <= with_sign(pn1[122:60], nneg_s4[1]);
			n_s5[2] <= sl_s4;
			h_s5 <= h_s4;
		end
	end

	// Squares, numerators and height terms.
	logic [63:0] nmag [3];
	logic [63:0] hmag;
	logic [127:0] pa [3];
	logic [127:0] pb [3];
	logic [127:0] ph [3];
	logic [127:0] pc [3];
	logic v_s6;
	logic v_s7;
	logic v_s8;
	logic v_s9;
	logic v_s10;
	logic [2:0] neg_s6;
	logic [2:0] neg_s7;
	logic hneg_s6;
	logic hneg_s7;
	post_t post_s8;
	post_t post_s9;
	post_t post_s10;
	logic [GW-1:0] g_s10;
	logic signed [63:0] ht_full [3];

	assign hmag = 64'(h_s5[31] ? 32'(-h_s5) : h_s5);

	for (genvar j = 0; j < 3; j++) begin : g_axis
		assign nmag[j] = mag64(n_s5[j]);
		assign ht_full[j] = with_sign(ph[j][102:40], neg_s7[j] ^ hneg_s7);
		g2c_mul u_mul_a (.clk(clk), .en(adv), .a(nmag[j]), .b(nmag[j]), .p(pa[j]));
		g2c_mul u_mul_b (.clk(clk), .en(adv), .a(64'(r2_q[j]) * 64'd1000), .b(nmag[j]),
			.p(pb[j]));
		g2c_mul u_mul_h (.clk(clk), .en(adv), .a(nmag[j]), .b(hmag), .p(ph[j]));
		g2c_mul u_mul_c (.clk(clk), .en(adv), .a(64'(r2_q[j])), .b(pa[j][123:60]),
			.p(pc[j]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s6 <= {n_s5[2][63], n_s5[1][63], n_s5[0][63]};
			hneg_s6 <= h_s5[31];
			neg_s7 <= neg_s6;
			hneg_s7 <= hneg_s6;
			post_s8.neg <= neg_s7;
			for (int j = 0; j < 3; j++) begin
				post_s8.num[j] <= pb[j][127:10];
				post_s8.ht[j] <= ht_full[j][HTW-1:0];
			end
			post_s9 <= post_s8;
			post_s10 <= post_s9;
			g_s10 <= GW'(pc[0] + pc[1] + pc[2]);
		end
	end

	// Square root row.
	logic sv [SQ_BITS+1];
	logic [GW-1:0] srem [SQ_BITS+1];
	logic [SQ_BITS-1:0] sres [SQ_BITS+1];
	post_t spost [SQ_BITS+1];

	assign sv[0] = v_s10;
	assign srem[0] = g_s10;
	assign sres[0] = '0;
	assign spost[0] = post_s10;

	for (genvar i = 0; i < SQ_BITS; i++) begin : g_sqrt
		g2c_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .bit_idx(SQB_W'(SQ_BITS - 1 - i)),
			.in_v(sv[i]), .in_rem(srem[i]), .in_res(sres[i]), .in_post(spost[i]),
			.out_v(sv[i+1]), .out_rem(srem[i+1]), .out_res(sres[i+1]),
			.out_post(spost[i+1])
		);
	end

	// Divider row.
	logic dv [DIV_STEPS+1];
	logic [SQ_BITS-1:0] dgamma [DIV_STEPS+1];
	div_lane_t [2:0] dlane [DIV_STEPS+1];
	logic [53:0] nh [3];

	assign dv[0] = sv[SQ_BITS];
	assign dgamma[0] = sres[SQ_BITS];

	for (genvar j = 0; j < 3; j++) begin : g_div_init
		assign nh[j] = spost[SQ_BITS].num[j][NUMW-1:64];
		assign dlane[0][j].rem = 58'(nh[j]);
		assign dlane[0][j].quo = spost[SQ_BITS].num[j][63:0];
		assign dlane[0][j].zero = sres[SQ_BITS] == '0;
		assign dlane[0][j].cap = 58'(nh[j]) >= sres[SQ_BITS];
		assign dlane[0][j].neg = spost[SQ_BITS].neg[j];
		assign dlane[0][j].ht = spost[SQ_BITS].ht[j];
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		g2c_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_v(dv[i]), .in_gamma(dgamma[i]), .in_lane(dlane[i]),
			.out_v(dv[i+1]), .out_gamma(dgamma[i+1]), .out_lane(dlane[i+1])
		);
	end

	// Final sum, rounding and saturation.
	logic [39:0] pos_nx [3];
	logic [63:0] q;
	logic signed [63:0] v;
	logic signed [63:0] w;
	logic v_s11;
	out_t res_s11;

	always_comb begin
		q = '0;
		v = '0;
		w = '0;
		for (int j = 0; j < 3; j++) begin
			if (dlane[DIV_STEPS][j].zero) q = '0;
			else if (dlane[DIV_STEPS][j].cap) q = QUOT_CAP;
			else if (dlane[DIV_STEPS][j].quo > QUOT_CAP) q = QUOT_CAP;
			else q = dlane[DIV_STEPS][j].quo;
			v = with_sign(q[62:0], dlane[DIV_STEPS][j].neg)
				+ 64'($signed(dlane[DIV_STEPS][j].ht));
			w = (v + ROUND_HALF) >>> 20;
			if (w > OUT_MAX) pos_nx[j] = POS_MAX;
			else if (w < OUT_MIN) pos_nx[j] = POS_MIN;
			else pos_nx[j] = w[39:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s11 <= dv[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s11 <= '{pos_x: pos_nx[0], pos_y: pos_nx[1], pos_z: pos_nx[2]};
		end
	end

	// Output register and skid register.
	logic ov_q;
	logic sk_v_q;
	out_t out_q;
	out_t sk_q;
	logic take;
	logic push;

	assign adv = !sk_v_q;
	assign take = ov_q && coord_out.ready;
	assign push = adv && v_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (push) begin
			if (ov_q && !take) sk_v_q <= 1'b1;
			ov_q <= 1'b1;
		end else if (take) begin
			if (sk_v_q) sk_v_q <= 1'b0;
			else ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (ov_q && !take) sk_q <= res_s11;
			else out_q <= res_s11;
		end else if (take && sk_v_q) begin
			out_q <= sk_q;
		end
	end

	assign coord_in.ready = adv;
	assign coord_out.valid = ov_q;
	assign coord_out.pos_x = out_q.pos_x;
	assign coord_out.pos_y = out_q.pos_y;
	assign coord_out.pos_z = out_q.pos_z;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> ov_q)
		else $error("skid register holds a transaction while the output is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sk_v_q && !take) |=> (sk_v_q && $stable(sk_q)))
		else $error("skid register lost or changed a waiting transaction");

	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s11 && !adv) |=> (v_s11 && $stable(res_s11)))
		else $error("last pipeline stage changed while stalled");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(take && sk_v_q) |=> (ov_q && !sk_v_q))
		else $error("skid register did not move to the output register");
endmodule
